>>> rtl/core/phong_local_shading_macros.svh
// Assertion macros shared by the shading core.
`ifndef PHONG_LOCAL_SHADING_MACROS_SVH
`define PHONG_LOCAL_SHADING_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define PLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pls_pkg.sv
// Shared types, constants and helpers of the Phong shading core.
`timescale 1ns / 1ps
package pls_pkg;

  localparam int          QUEUE_DEPTH_DEF = 4;
  localparam logic [16:0] SAT_OUT         = 17'd98304;
  localparam int          ONE_Q14         = 16384;

  typedef enum logic [2:0] {
    CFG_AMBIENT  = 3'd0,
    CFG_DIFFUSE  = 3'd1,
    CFG_SPECULAR = 3'd2,
    CFG_LIGHT    = 3'd3,
    CFG_EYE      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] la;
    logic [47:0] ld;
    logic [47:0] ls;
    logic [47:0] lpos;
    logic [47:0] epos;
  } cfg_t;

  // Item as it leaves the front: direction vectors and colour products.
  typedef struct packed {
    logic [2:0][16:0] dl;
    logic [2:0][16:0] dv;
    logic [2:0][15:0] nrm;
    logic [7:0]       shin;
    logic [2:0][16:0] amb;
    logic [2:0][31:0] dm;
    logic [2:0][31:0] sm;
  } q_item_t;

  // Channel k of a packed triple, k = 0 is the top lane (red or x).
  function automatic logic [15:0] chan16(input logic [47:0] v, input int k);
    return v[47-16*k -: 16];
  endfunction

  function automatic logic signed [16:0] ext17(input logic [15:0] a);
    return $signed({a[15], a});
  endfunction

endpackage

>>> rtl/core/pls_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module pls_isqrt #(
  parameter int N  = 18,
  parameter int TW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  logic [2*N-1:0] x_i,
  input  logic [TW-1:0]  tag_i,
  output logic           vld_o,
  output logic [N-1:0]   root_o,
  output logic [TW-1:0]  tag_o
);

  logic [N-1:0]   vld_r;
  logic [2*N-1:0] x_r    [N];
  logic [N+1:0]   rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic [TW-1:0]  tag_r  [N];

  for (genvar s = 0; s < N; s++) begin : g_stg
    logic           vld_in;
    logic [2*N-1:0] x_in;
    logic [N+1:0]   rem_in;
    logic [N-1:0]   root_in;
    logic [TW-1:0]  tag_in;
    logic [N+1:0]   rem_sh;
    logic [N+1:0]   trial;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign tag_in  = tag_r[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in[N-1:0], x_in[2*N-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[s]   <= {x_in[2*N-3:0], 2'b00};
      tag_r[s] <= tag_in;
      if (rem_sh >= trial) begin
        rem_r[s]  <= rem_sh - trial;
        root_r[s] <= {root_in[N-2:0], 1'b1};
      end else begin
        rem_r[s]  <= rem_sh;
        root_r[s] <= {root_in[N-2:0], 1'b0};
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign root_o = root_r[N-1];
  assign tag_o  = tag_r[N-1];

endmodule

>>> rtl/core/pls_udiv.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pls_udiv #(
  parameter int NW = 33,
  parameter int DW = 19,
  parameter int QW = 15,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0] vld_r;
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic [EW-1:0] rem_x;
    logic [EW-1:0] dsh;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    assign rem_x = EW'(rem_in);
    assign dsh   = EW'(den_in) << (QW - 1 - s);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      den_r[s] <= den_in;
      tag_r[s] <= tag_in;
      if (rem_x >= dsh) begin
        rem_r[s] <= NW'(rem_x - dsh);
        quo_r[s] <= quo_in | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_r[s] <= rem_in;
        quo_r[s] <= quo_in;
      end
    end
  end

  assign vld_o = vld_r[QW-1];
  assign quo_o = quo_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

>>> rtl/core/pls_norm.sv
// Vector normalizer: squared length, square root, then one divider per lane.
`timescale 1ns / 1ps
module pls_norm #(
  parameter int CW = 17,
  parameter int TW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [2:0][CW-1:0]  c_i,
  input  logic [TW-1:0]       tag_i,
  output logic                vld_o,
  output logic [2:0][15:0]    u_o,
  output logic                ok_o,
  output logic [TW-1:0]       tag_o
);

  localparam int SW  = 2 * CW + 2;
  localparam int N   = CW + 1;
  localparam int NW  = CW + 16;
  localparam int DW  = CW + 2;
  localparam int QW  = 15;
  localparam int TWI = TW + 3 * CW + 3;

  // squared length
  logic                a_vld_r;
  logic [SW-1:0]       a_sum_r;
  logic [2:0][CW-1:0]  a_mag_r;
  logic [2:0]          a_neg_r;
  logic [TW-1:0]       a_tag_r;
  logic [2:0][CW-1:0]  mag;
  logic [SW-1:0]       sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = c_i[i][CW-1] ? CW'(-$signed(c_i[i])) : c_i[i];
      sum_nxt = sum_nxt + SW'(SW'(mag[i]) * SW'(mag[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    a_sum_r <= sum_nxt;
    a_mag_r <= mag;
    for (int i = 0; i < 3; i++) begin
      a_neg_r[i] <= c_i[i][CW-1];
    end
    a_tag_r <= tag_i;
  end

  logic               sq_vld;
  logic [N-1:0]       sq_len;
  logic [TWI-1:0]     sq_tag;

  pls_isqrt #(.N(N), .TW(TWI)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (a_vld_r),
    .x_i    (a_sum_r),
    .tag_i  ({a_tag_r, a_mag_r, a_neg_r}),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .tag_o  (sq_tag)
  );

  // dividend and divisor set-up
  logic                b_vld_r;
  logic [2:0][NW-1:0]  b_num_r;
  logic [DW-1:0]       b_den_r;
  logic                b_ok_r;
  logic [2:0]          b_neg_r;
  logic [TW-1:0]       b_tag_r;
  logic [2:0][CW-1:0]  sq_mag;

  assign sq_mag = sq_tag[3 +: 3*CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b_num_r[i] <= (NW'(sq_mag[i]) << 15) + NW'(sq_len);
    end
    // zero length: keep the divider away from a zero divisor, result dropped
    b_den_r <= (sq_len == '0) ? DW'(1) : {sq_len, 1'b0};
    b_ok_r  <= (sq_len != '0);
    b_neg_r <= sq_tag[2:0];
    b_tag_r <= sq_tag[TWI-1 -: TW];
  end

  logic [2:0]           dv_vld;
  logic [2:0][QW-1:0]   dv_quo;
  logic [TW+1:0]        dv_tag0;
  logic                 dv_neg1;
  logic                 dv_neg2;

  pls_udiv #(.NW(NW), .DW(DW), .QW(QW), .TW(TW + 2)) u_div0 (
    .clk (clk), .rst_n (rst_n),
    .vld_i (b_vld_r), .num_i (b_num_r[0]), .den_i (b_den_r),
    .tag_i ({b_tag_r, b_ok_r, b_neg_r[0]}),
    .vld_o (dv_vld[0]), .quo_o (dv_quo[0]), .tag_o (dv_tag0)
  );

  pls_udiv #(.NW(NW), .DW(DW), .QW(QW), .TW(1)) u_div1 (
    .clk (clk), .rst_n (rst_n),
    .vld_i (b_vld_r), .num_i (b_num_r[1]), .den_i (b_den_r),
    .tag_i (b_neg_r[1]),
    .vld_o (dv_vld[1]), .quo_o (dv_quo[1]), .tag_o (dv_neg1)
  );

  pls_udiv #(.NW(NW), .DW(DW), .QW(QW), .TW(1)) u_div2 (
    .clk (clk), .rst_n (rst_n),
    .vld_i (b_vld_r), .num_i (b_num_r[2]), .den_i (b_den_r),
    .tag_i (b_neg_r[2]),
    .vld_o (dv_vld[2]), .quo_o (dv_quo[2]), .tag_o (dv_neg2)
  );

  logic [2:0] neg_o;
  assign neg_o = {dv_neg2, dv_neg1, dv_tag0[0]};
  assign ok_o  = dv_tag0[1];
  assign tag_o = dv_tag0[TW+1 -: TW];
  assign vld_o = dv_vld[0] & dv_vld[1] & dv_vld[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!ok_o) begin
        u_o[i] = '0;
      end else if (neg_o[i]) begin
        u_o[i] = 16'(-$signed({1'b0, dv_quo[i]}));
      end else begin
        u_o[i] = {1'b0, dv_quo[i]};
      end
    end
  end

endmodule

>>> rtl/core/pls_front.sv
// Front end: takes items, forms direction vectors and colour products, queues them.
`timescale 1ns / 1ps
module pls_front #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [15:0]      in_point_x,
  input  logic [15:0]      in_point_y,
  input  logic [15:0]      in_point_z,
  input  logic [15:0]      in_normal_x,
  input  logic [15:0]      in_normal_y,
  input  logic [15:0]      in_normal_z,
  input  logic [47:0]      in_mat_ambient_rgb,
  input  logic [47:0]      in_mat_diffuse_rgb,
  input  logic [47:0]      in_mat_specular_rgb,
  input  logic [7:0]       in_shininess,
  input  pls_pkg::cfg_t    cfg,
  output logic             q_vld_o,
  output pls_pkg::q_item_t q_item_o
);
  import pls_pkg::*;

  `include "phong_local_shading_macros.svh"

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;

  logic          stg_vld_r;
  q_item_t       stg_r;
  q_item_t       stg_nxt;
  q_item_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          accept;
  logic          push;
  logic          pop;
  logic [15:0]   pt_a  [3];
  logic [15:0]   nrm_a [3];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // leave room for the item already in the staging register
  assign busy   = (CW1'(cnt_r) + CW1'(stg_vld_r)) > CW1'(DEPTH - 1);
  assign accept = start && !busy;
  assign push   = stg_vld_r;
  assign pop    = (cnt_r != '0);

  assign pt_a[0]  = in_point_x;
  assign pt_a[1]  = in_point_y;
  assign pt_a[2]  = in_point_z;
  assign nrm_a[0] = in_normal_x;
  assign nrm_a[1] = in_normal_y;
  assign nrm_a[2] = in_normal_z;

  always_comb begin
    stg_nxt = stg_r;
    for (int i = 0; i < 3; i++) begin
      stg_nxt.dl[i]  = ext17(chan16(cfg.lpos, i)) - ext17(pt_a[i]);
      stg_nxt.dv[i]  = ext17(chan16(cfg.epos, i)) - ext17(pt_a[i]);
      stg_nxt.nrm[i] = nrm_a[i];
      stg_nxt.amb[i] = 17'((33'(chan16(cfg.la, i)) * 33'(chan16(in_mat_ambient_rgb, i))
                            + 33'd16384) >> 15);
      stg_nxt.dm[i]  = 32'(chan16(cfg.ld, i)) * 32'(chan16(in_mat_diffuse_rgb, i));
      stg_nxt.sm[i]  = 32'(chan16(cfg.ls, i)) * 32'(chan16(in_mat_specular_rgb, i));
    end
    stg_nxt.shin = in_shininess;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      q_vld_o   <= 1'b0;
    end else begin
      stg_vld_r <= accept;
      q_vld_o   <= pop;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= CW'(CW1'(cnt_r) + CW1'(push) - CW1'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= stg_r;
    end
    if (pop) begin
      q_item_o <= mem[rd_ptr_r];
    end
  end

  `PLS_ASSERT_IMPL(a_queue_room, push, cnt_r < CW'(DEPTH), "queue push with no free entry")
  `PLS_ASSERT_NEXT(a_accept_stage, accept, stg_vld_r, "accepted item lost before staging")
  `PLS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

>>> rtl/core/pls_back.sv
// Back end: normalize, dot products, reflection, specular power and colour sum.
`timescale 1ns / 1ps
module pls_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  pls_pkg::q_item_t item,
  output logic             out_valid,
  output logic [16:0]      out_red,
  output logic [16:0]      out_green,
  output logic [16:0]      out_blue
);
  import pls_pkg::*;

  typedef struct packed {
    logic [2:0][16:0] amb;
    logic [2:0][31:0] dm;
    logic [2:0][31:0] sm;
  } col_t;

  typedef struct packed {
    logic [2:0][15:0] nrm;
    col_t             col;
  } ltag_t;

  typedef struct packed {
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] l;
    logic             l_ok;
    logic [2:0][15:0] v;
    logic             v_ok;
    logic [7:0]       shin;
    col_t             col;
  } ctx_t;

  typedef struct packed {
    logic [2:0][15:0] v;
    logic             v_ok;
    logic             l_ok;
    logic [14:0]      dfac;
    logic [7:0]       shin;
    col_t             col;
  } rtag_t;

  typedef struct packed {
    logic        ok;
    logic [14:0] dfac;
    logic [7:0]  shin;
    col_t        col;
  } ptag_t;

  localparam int PS = 8;

  function automatic logic signed [35:0] rnd14(input logic signed [35:0] x);
    logic signed [35:0] a;
    begin
      a = -x;
      if (x >= 0) begin
        rnd14 = (x + 36'sd8192) >>> 14;
      end else begin
        rnd14 = -((a + 36'sd8192) >>> 14);
      end
    end
  endfunction

  function automatic logic [14:0] clamp1(input logic signed [35:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > 36'sd16384) begin
      return 15'(ONE_Q14);
    end
    return x[14:0];
  endfunction

  // light and view directions
  logic             ln_vld;
  logic [2:0][15:0] l_u;
  logic             l_ok;
  ltag_t            ln_tag;
  logic             vn_vld;
  logic [2:0][15:0] v_u;
  logic             v_ok;
  logic [7:0]       vn_shin;

  pls_norm #(.CW(17), .TW($bits(ltag_t))) u_norm_l (
    .clk (clk), .rst_n (rst_n),
    .vld_i (item_vld), .c_i (item.dl),
    .tag_i ({item.nrm, item.amb, item.dm, item.sm}),
    .vld_o (ln_vld), .u_o (l_u), .ok_o (l_ok), .tag_o (ln_tag)
  );

  pls_norm #(.CW(17), .TW(8)) u_norm_v (
    .clk (clk), .rst_n (rst_n),
    .vld_i (item_vld), .c_i (item.dv), .tag_i (item.shin),
    .vld_o (vn_vld), .u_o (v_u), .ok_o (v_ok), .tag_o (vn_shin)
  );

  ctx_t ctx0;
  always_comb begin
    ctx0.nrm  = ln_tag.nrm;
    ctx0.l    = l_u;
    ctx0.l_ok = l_ok;
    ctx0.v    = v_u;
    ctx0.v_ok = v_ok;
    ctx0.shin = vn_shin;
    ctx0.col  = ln_tag.col;
  end

  // l.n products
  logic                     b1_vld_r;
  logic signed [31:0]       b1_prod_r [3];
  ctx_t                     b1_ctx_r;
  // l.n rounded, diffuse factor
  logic                     b2_vld_r;
  logic signed [18:0]       b2_lnq_r;
  logic [14:0]              b2_dfac_r;
  ctx_t                     b2_ctx_r;
  // 2(l.n)n
  logic                     b3_vld_r;
  logic signed [35:0]       b3_p2_r [3];
  logic [14:0]              b3_dfac_r;
  ctx_t                     b3_ctx_r;
  // reflection vector
  logic                     b4_vld_r;
  logic [2:0][20:0]         b4_dr_r;
  rtag_t                    b4_tag_r;

  logic signed [33:0]       dot_ln;
  logic signed [35:0]       lnq_w;

  assign dot_ln = 34'(b1_prod_r[0]) + 34'(b1_prod_r[1]) + 34'(b1_prod_r[2]);
  assign lnq_w  = rnd14(36'(dot_ln));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
      b4_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= ln_vld & vn_vld;
      b2_vld_r <= b1_vld_r;
      b3_vld_r <= b2_vld_r;
      b4_vld_r <= b3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b1_prod_r[i] <= $signed(ctx0.l[i]) * $signed(ctx0.nrm[i]);
    end
    b1_ctx_r <= ctx0;

    b2_lnq_r  <= lnq_w[18:0];
    b2_dfac_r <= b1_ctx_r.l_ok ? clamp1(lnq_w) : '0;
    b2_ctx_r  <= b1_ctx_r;

    for (int i = 0; i < 3; i++) begin
      b3_p2_r[i] <= (36'(b2_lnq_r) * 36'($signed(b2_ctx_r.nrm[i]))) <<< 1;
    end
    b3_dfac_r <= b2_dfac_r;
    b3_ctx_r  <= b2_ctx_r;

    for (int i = 0; i < 3; i++) begin
      b4_dr_r[i] <= 21'(rnd14(b3_p2_r[i]) - 36'($signed(b3_ctx_r.l[i])));
    end
    b4_tag_r.v    <= b3_ctx_r.v;
    b4_tag_r.v_ok <= b3_ctx_r.v_ok;
    b4_tag_r.l_ok <= b3_ctx_r.l_ok;
    b4_tag_r.dfac <= b3_dfac_r;
    b4_tag_r.shin <= b3_ctx_r.shin;
    b4_tag_r.col  <= b3_ctx_r.col;
  end

  // reflection direction
  logic             rn_vld;
  logic [2:0][15:0] r_u;
  logic             r_ok;
  rtag_t            rn_tag;

  pls_norm #(.CW(21), .TW($bits(rtag_t))) u_norm_r (
    .clk (clk), .rst_n (rst_n),
    .vld_i (b4_vld_r), .c_i (b4_dr_r), .tag_i (b4_tag_r),
    .vld_o (rn_vld), .u_o (r_u), .ok_o (r_ok), .tag_o (rn_tag)
  );

  // r.v and specular base
  logic               b5_vld_r;
  logic signed [31:0] b5_prod_r [3];
  logic               b5_ok_r;
  rtag_t              b5_tag_r;
  logic               b6_vld_r;
  logic [14:0]        b6_base_r;
  ptag_t              b6_tag_r;
  logic signed [33:0] dot_rv;

  assign dot_rv = 34'(b5_prod_r[0]) + 34'(b5_prod_r[1]) + 34'(b5_prod_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b5_vld_r <= 1'b0;
      b6_vld_r <= 1'b0;
    end else begin
      b5_vld_r <= rn_vld;
      b6_vld_r <= b5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b5_prod_r[i] <= $signed(r_u[i]) * $signed(rn_tag.v[i]);
    end
    b5_ok_r  <= r_ok & rn_tag.l_ok & rn_tag.v_ok;
    b5_tag_r <= rn_tag;

    b6_base_r     <= clamp1(rnd14(36'(dot_rv)));
    b6_tag_r.ok   <= b5_ok_r;
    b6_tag_r.dfac <= b5_tag_r.dfac;
    b6_tag_r.shin <= b5_tag_r.shin;
    b6_tag_r.col  <= b5_tag_r.col;
  end

  // square-and-multiply, one exponent bit per stage
  logic [PS-1:0] pw_vld_r;
  logic [14:0]   pw_p_r [PS];
  logic [14:0]   pw_b_r [PS];
  ptag_t         pw_tag_r [PS];

  for (genvar k = 0; k < PS; k++) begin : g_pow
    logic        vld_in;
    logic [14:0] p_in;
    logic [14:0] b_in;
    ptag_t       tag_in;
    logic [29:0] pb;
    logic [29:0] bb;

    if (k == 0) begin : g_first
      assign vld_in = b6_vld_r;
      assign p_in   = 15'(ONE_Q14);
      assign b_in   = b6_base_r;
      assign tag_in = b6_tag_r;
    end else begin : g_next
      assign vld_in = pw_vld_r[k-1];
      assign p_in   = pw_p_r[k-1];
      assign b_in   = pw_b_r[k-1];
      assign tag_in = pw_tag_r[k-1];
    end

    assign pb = (30'(p_in) * 30'(b_in) + 30'd8192) >> 14;
    assign bb = (30'(b_in) * 30'(b_in) + 30'd8192) >> 14;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_vld_r[k] <= 1'b0;
      end else begin
        pw_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      pw_p_r[k]   <= tag_in.shin[k] ? pb[14:0] : p_in;
      pw_b_r[k]   <= bb[14:0];
      pw_tag_r[k] <= tag_in;
    end
  end

  // diffuse and specular terms, colour sum and saturation
  ptag_t            pt_fin;
  logic [14:0]      p_fin;
  logic             t1_vld_r;
  logic [2:0][16:0] t1_amb_r;
  logic [2:0][17:0] t1_dif_r;
  logic [2:0][17:0] t1_spc_r;
  logic [2:0][19:0] sum;

  assign pt_fin = pw_tag_r[PS-1];
  assign p_fin  = pt_fin.ok ? pw_p_r[PS-1] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      t1_vld_r  <= pw_vld_r[PS-1];
      out_valid <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_amb_r <= pt_fin.col.amb;
    for (int i = 0; i < 3; i++) begin
      t1_dif_r[i] <= 18'((47'(pt_fin.col.dm[i]) * 47'(pt_fin.dfac) + 47'(1 << 28)) >> 29);
      t1_spc_r[i] <= 18'((47'(pt_fin.col.sm[i]) * 47'(p_fin) + 47'(1 << 28)) >> 29);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 20'(t1_amb_r[i]) + 20'(t1_dif_r[i]) + 20'(t1_spc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= (sum[0] > 20'(SAT_OUT)) ? SAT_OUT : sum[0][16:0];
    out_green <= (sum[1] > 20'(SAT_OUT)) ? SAT_OUT : sum[1][16:0];
    out_blue  <= (sum[2] > 20'(SAT_OUT)) ? SAT_OUT : sum[2][16:0];
  end

endmodule

>>> rtl/core/phong_local_shading.sv
// Top level of the Phong shading core: configuration registers, front, back.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ---------------------------------
//   input     in         start / busy           hit point, normal, materials, shin
//   result    out        out_valid strobe       red, green, blue (Q2.15)
//   config    in         cfg_we                 cfg_index, cfg_wdata (48 bits)
//
// One item per clock: every stage is a register stage and no stage waits on
// another, so start may be held high and an item enters each cycle.
// From the accepting edge to out_valid an item passes the front (queue write,
// queue read), the light/view normalize, l.n and the reflection, the reflection
// normalize, r.v, the specular power and the colour sum.
// Reset (rst_n low, synchronous) clears all valid bits, the queue and the
// configuration registers; there is no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall it. The back drains
// one queue entry per cycle; with QUEUE_DEPTH >= 3 it never fills, busy stays low.
`timescale 1ns / 1ps
module phong_local_shading #(
  parameter int QUEUE_DEPTH = pls_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [15:0] in_point_z,
  input  logic [15:0] in_normal_x,
  input  logic [15:0] in_normal_y,
  input  logic [15:0] in_normal_z,
  input  logic [47:0] in_mat_ambient_rgb,
  input  logic [47:0] in_mat_diffuse_rgb,
  input  logic [47:0] in_mat_specular_rgb,
  input  logic [7:0]  in_shininess,
  output logic        out_valid,
  output logic [16:0] out_red,
  output logic [16:0] out_green,
  output logic [16:0] out_blue,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import pls_pkg::*;

  `include "phong_local_shading_macros.svh"

  cfg_t    cfg_r;
  logic    q_vld;
  q_item_t q_item;

  // Register file; writes to unused indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AMBIENT:  cfg_r.la   <= cfg_wdata;
        CFG_DIFFUSE:  cfg_r.ld   <= cfg_wdata;
        CFG_SPECULAR: cfg_r.ls   <= cfg_wdata;
        CFG_LIGHT:    cfg_r.lpos <= cfg_wdata;
        CFG_EYE:      cfg_r.epos <= cfg_wdata;
        default:      cfg_r      <= cfg_r;
      endcase
    end
  end

  // Front: accept, form light/eye vectors and colour products, queue.
  pls_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_point_z          (in_point_z),
    .in_normal_x         (in_normal_x),
    .in_normal_y         (in_normal_y),
    .in_normal_z         (in_normal_z),
    .in_mat_ambient_rgb  (in_mat_ambient_rgb),
    .in_mat_diffuse_rgb  (in_mat_diffuse_rgb),
    .in_mat_specular_rgb (in_mat_specular_rgb),
    .in_shininess        (in_shininess),
    .cfg                 (cfg_r),
    .q_vld_o             (q_vld),
    .q_item_o            (q_item)
  );

  // Back: drain the queue each cycle, shade, drive the result strobe.
  pls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (q_vld),
    .item      (q_item),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  `PLS_ASSERT_IMPL(a_sat_red, out_valid, out_red <= SAT_OUT, "red above saturation")
  `PLS_ASSERT_IMPL(a_sat_grn, out_valid, out_green <= SAT_OUT, "green above saturation")
  `PLS_ASSERT_IMPL(a_sat_blu, out_valid, out_blue <= SAT_OUT, "blue above saturation")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the Phong local shading core.
`timescale 1ns / 1ps
module tb_top;
  import pls_pkg::*;

  localparam int N_RANDOM   = 1150;
  localparam int DRAIN_WAIT = 150;
  localparam int STALL_MAX  = 20000;

  typedef struct {
    logic [15:0] px, py, pz, nx, ny, nz;
    logic [47:0] ma, md, ms;
    logic [7:0]  shin;
  } hit_t;

  typedef struct {
    logic [16:0] r, g, b;
  } rgb_t;

  // One row of the directed table; known marks a hand-typed expected color.
  typedef struct {
    hit_t h;
    bit   known;
    rgb_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [47:0] in_mat_ambient_rgb = '0, in_mat_diffuse_rgb = '0, in_mat_specular_rgb = '0;
  logic [7:0]  in_shininess = '0;
  logic        out_valid;
  logic [16:0] out_red, out_green, out_blue;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  // Local copy of the light setup, indexed by register.
  logic [47:0] light_regs [5];
  rgb_t        shade_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;

  always #5 clk = ~clk;

  phong_local_shading u_top (.*);

  // Signed Q8.8 / Q1.14 lane of a packed triple, k = 0 is the top lane.
  function automatic longint lane_s(input logic [47:0] v, input int k);
    return longint'($signed(v[47-16*k -: 16]));
  endfunction

  function automatic longint lane_u(input logic [47:0] v, input int k);
    return longint'({1'b0, v[47-16*k -: 16]});
  endfunction

  function automatic longint rnd_shift(input longint x, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (x >= 0) return (x + half) >>> sh;
    return -((-x + half) >>> sh);
  endfunction

  function automatic longint int_sqrt(input longint x);
    longint r, bit_v;
    r = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > x) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x = x - (r + bit_v);
        r = (r >>> 1) + bit_v;
      end else begin
        r = r >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return r;
  endfunction

  // Normalize to Q1.14; returns 0 for a zero-length vector.
  function automatic bit to_unit(input longint c[3], output longint u[3]);
    longint s, len, m, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += c[i] * c[i];
    if (s == 0) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      q = (m * 32768 + len) / (2 * len);
      u[i] = c[i] < 0 ? -q : q;
    end
    return 1'b1;
  endfunction

  function automatic longint clamp_q14(input longint x);
    if (x < 0) return 0;
    return x > ONE_Q14 ? ONE_Q14 : x;
  endfunction

  // Expected color of one hit under the current light setup.
  function automatic rgb_t shade_hit(input hit_t h);
    longint pt[3], nrm[3], dl[3], dv[3], dr[3], l[3], v[3], rf[3];
    longint ln, diff_f, spec_p, b, amb, dif, spc, sum;
    logic [47:0] pin, nin;
    bit l_ok, v_ok, r_ok;
    logic [7:0] s;
    longint ch[3];
    rgb_t res;
    pin = {h.px, h.py, h.pz};
    nin = {h.nx, h.ny, h.nz};
    r_ok = 1'b0;
    diff_f = 0;
    spec_p = 0;
    for (int i = 0; i < 3; i++) begin
      pt[i]  = lane_s(pin, i);
      nrm[i] = lane_s(nin, i);
      dl[i]  = lane_s(light_regs[CFG_LIGHT], i) - pt[i];
      dv[i]  = lane_s(light_regs[CFG_EYE], i) - pt[i];
    end
    l_ok = to_unit(dl, l);
    v_ok = to_unit(dv, v);
    if (l_ok) begin
      ln = rnd_shift(l[0]*nrm[0] + l[1]*nrm[1] + l[2]*nrm[2], 14);
      diff_f = clamp_q14(ln);
      for (int i = 0; i < 3; i++) dr[i] = rnd_shift(2 * ln * nrm[i], 14) - l[i];
      r_ok = to_unit(dr, rf);
    end
    if (l_ok && v_ok && r_ok) begin
      b = clamp_q14(rnd_shift(rf[0]*v[0] + rf[1]*v[1] + rf[2]*v[2], 14));
      spec_p = ONE_Q14;
      s = h.shin;
      while (s != 0) begin
        if (s[0]) spec_p = (spec_p * b + 8192) >>> 14;
        b = (b * b + 8192) >>> 14;
        s = s >> 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      amb = (lane_u(light_regs[CFG_AMBIENT], i) * lane_u(h.ma, i) + 16384) >>> 15;
      dif = (lane_u(light_regs[CFG_DIFFUSE], i) * lane_u(h.md, i) * diff_f
             + (longint'(1) << 28)) >>> 29;
      spc = (lane_u(light_regs[CFG_SPECULAR], i) * lane_u(h.ms, i) * spec_p
             + (longint'(1) << 28)) >>> 29;
      sum = amb + dif + spc;
      ch[i] = sum > longint'(SAT_OUT) ? longint'(SAT_OUT) : sum;
    end
    res.r = ch[0][16:0];
    res.g = ch[1][16:0];
    res.b = ch[2][16:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Result monitor: every strobe must meet the oldest expected color.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (shade_q.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result at %0t", $realtime);
      end else begin
        rgb_t e;
        e = shade_q.pop_front();
        if (out_red !== e.r)   report_mismatch("red", out_red, e.r);
        if (out_green !== e.g) report_mismatch("green", out_green, e.g);
        if (out_blue !== e.b)  report_mismatch("blue", out_blue, e.b);
      end
    end
  end

  // Watchdog: count cycles with no accepted item or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    light_regs[idx] = val;
  endtask

  // Drain in-flight items, then hold for the pipeline depth.
  task automatic wait_quiet();
    while (shade_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Present one item and hold start until it is taken; random gaps go ahead.
  task automatic send_hit(input hit_t h, input bit known, input rgb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= h.px;  in_point_y <= h.py;  in_point_z <= h.pz;
    in_normal_x <= h.nx; in_normal_y <= h.ny; in_normal_z <= h.nz;
    in_mat_ambient_rgb <= h.ma;
    in_mat_diffuse_rgb <= h.md;
    in_mat_specular_rgb <= h.ms;
    in_shininess <= h.shin;
    do @(posedge clk); while (busy);
    // Accepted at this edge; expected color uses the setup in force now.
    shade_q.push_back(known ? want : shade_hit(h));
  endtask

  function automatic logic [15:0] rnd_unit_lane();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Random hit: mostly true unit normals, sometimes raw noise.
  function automatic hit_t rnd_hit();
    hit_t h;
    longint c[3], u[3];
    bit ok;
    h.px = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(4096) - 2048);
    h.py = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(4096) - 2048);
    h.pz = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(4096) - 2048);
    if ($urandom_range(9) == 0) begin
      h.nx = 16'($urandom); h.ny = 16'($urandom); h.nz = 16'($urandom);
    end else begin
      c[0] = $signed(rnd_unit_lane());
      c[1] = $signed(rnd_unit_lane());
      c[2] = $signed(rnd_unit_lane());
      ok = to_unit(c, u);
      h.nx = 16'(u[0]); h.ny = 16'(u[1]); h.nz = 16'(u[2]);
      if (!ok) h.nz = 16'd16384;
    end
    h.ma = 48'({$urandom, $urandom});
    h.md = 48'({$urandom, $urandom});
    h.ms = 48'({$urandom, $urandom});
    h.shin = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(16));
    return h;
  endfunction

  function automatic hit_t mk(input logic [15:0] px, py, pz, nx, ny, nz,
                              input logic [47:0] m, input logic [7:0] s);
    hit_t h;
    h.px = px; h.py = py; h.pz = pz; h.nx = nx; h.ny = ny; h.nz = nz;
    h.ma = m; h.md = m; h.ms = m; h.shin = s;
    return h;
  endfunction

  task automatic rnd_setup(input bit extreme);
    write_reg(CFG_AMBIENT,  extreme ? '1 : 48'({$urandom, $urandom}));
    write_reg(CFG_DIFFUSE,  extreme ? '1 : 48'({$urandom, $urandom}));
    write_reg(CFG_SPECULAR, extreme ? '1 : 48'({$urandom, $urandom}));
    write_reg(CFG_LIGHT, {16'($urandom_range(8192) - 4096), 16'($urandom_range(8192) - 4096),
                          16'($urandom_range(8192) - 4096)});
    write_reg(CFG_EYE, extreme ? {16'h7fff, 16'h8000, 16'h7fff} :
                       {16'($urandom), 16'($urandom), 16'($urandom)});
  endtask

  initial begin
    row_t rows [$];
    rgb_t zero_rgb, sat_rgb, amb_rgb;
    zero_rgb = '{17'd0, 17'd0, 17'd0};
    sat_rgb  = '{SAT_OUT, SAT_OUT, SAT_OUT};
    for (int i = 0; i < 5; i++) light_regs[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset every light color is zero: black regardless of the hit.
    send_hit(mk('1, '1, '1, 16'h4000, 0, 0, '1, 8'hff), 1'b1, zero_rgb);
    start <= 1'b0;
    wait_quiet();

    // Directed setup: white diffuse and specular light above the origin, eye on the +z axis.
    write_reg(CFG_AMBIENT,  {16'h8000, 16'h4000, 16'h0000});
    write_reg(CFG_DIFFUSE,  '1);
    write_reg(CFG_SPECULAR, '1);
    write_reg(CFG_LIGHT,    {16'h0000, 16'h0000, 16'h0400});
    write_reg(CFG_EYE,      {16'h0000, 16'h0000, 16'h0800});
    // La*Ma with white material, normal facing away from light, so no diffuse term.
    amb_rgb = '{17'd32768, 17'd16384, 17'd0};
    rows.push_back('{mk(0, 0, 0, 0, 0, 16'hc000, {16'h8000, 16'h8000, 16'h8000}, 8'd0),
                     1'b0, zero_rgb});
    rows.push_back('{mk(0, 0, 0, 16'h4000, 0, 0, 48'h0, 8'd1), 1'b1, zero_rgb});
    // Head-on light, white material, max colors: saturates every channel.
    rows.push_back('{mk(0, 0, 0, 0, 0, 16'h4000, '1, 8'd0), 1'b1, sat_rgb});
    rows.push_back('{mk(0, 0, 0, 0, 0, 16'h4000, '1, 8'd255), 1'b0, zero_rgb});
    // Point at the light: zero-length light direction.
    rows.push_back('{mk(0, 0, 16'h0400, 0, 0, 16'h4000, '1, 8'd5), 1'b0, zero_rgb});
    // Point at the eye: zero-length view direction.
    rows.push_back('{mk(0, 0, 16'h0800, 0, 0, 16'hc000, '1, 8'd3), 1'b0, zero_rgb});
    // Grazing reflection, negative r.v, zero power base with shininess 0.
    rows.push_back('{mk(16'h0400, 0, 0, 16'h4000, 0, 0, '1, 8'd0), 1'b0, zero_rgb});
    rows.push_back('{mk(16'h0400, 0, 0, 16'h4000, 0, 0, '1, 8'd7), 1'b0, zero_rgb});
    rows.push_back('{mk(16'h0800, 0, 16'h0400, 16'hc000, 0, 0, '1, 8'd2), 1'b0, zero_rgb});
    // Unnormalized and extreme normals, extreme points.
    rows.push_back('{mk(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, '1, 8'd9),
                     1'b0, zero_rgb});
    rows.push_back('{mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '1, 8'd128),
                     1'b0, zero_rgb});
    rows.push_back('{mk(16'h8000, 16'h7fff, 16'h0001, 16'h2d41, 16'h2d41, 0, 48'h5555aaaa5555,
                        8'd64), 1'b0, zero_rgb});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, '1, 8'd1), 1'b0, zero_rgb});
    foreach (rows[i]) send_hit(rows[i].h, rows[i].known, rows[i].want);
    start <= 1'b0;
    wait_quiet();
    // Ambient-only check with light parked on the point is covered above;
    // here black diffuse/specular lights leave just the ambient term.
    write_reg(CFG_DIFFUSE, '0);
    write_reg(CFG_SPECULAR, '0);
    send_hit(mk(0, 0, 0, 0, 0, 16'h4000, {16'h8000, 16'h8000, 16'h8000}, 8'd4), 1'b1, amb_rgb);
    start <= 1'b0;
    wait_quiet();

    // Random phases: sender idling 13 percent, then 47, then none.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = ph < 2 ? 13 : (ph < 4 ? 47 : 0);
      rnd_setup(ph == 3);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        send_hit(rnd_hit(), 1'b0, zero_rgb);
        // Pause once per phase until the pipeline has emptied.
        if (n == 40) begin
          start <= 1'b0;
          while (shade_q.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      wait_quiet();
    end
    // Out-of-range index must not disturb the setup.
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int n = 0; n < 20; n++) send_hit(rnd_hit(), 1'b0, zero_rgb);
    start <= 1'b0;
    wait_quiet();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
